// File: hdl/stt_pkg.sv
package stt_pkg;

	// width of byte counters, offsets and run lengths inside the scanner
	localparam int POS_BITS = 16;
	localparam int OUT_BITS = 16;
	localparam int KIND_BITS = 6;

	// token queue between scanner and output stage
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);

	// token kinds
	localparam logic [KIND_BITS-1:0] KIND_ID    = 6'd0;
	localparam logic [KIND_BITS-1:0] KIND_INT   = 6'd1;
	localparam logic [KIND_BITS-1:0] KIND_DEF   = 6'd2;
	localparam logic [KIND_BITS-1:0] KIND_WHILE = 6'd3;
	localparam logic [KIND_BITS-1:0] KIND_FOR   = 6'd4;
	localparam logic [KIND_BITS-1:0] KIND_LET   = 6'd5;
	localparam logic [KIND_BITS-1:0] KIND_RET   = 6'd6;
	localparam logic [KIND_BITS-1:0] KIND_IF    = 6'd7;
	localparam logic [KIND_BITS-1:0] KIND_ELIF  = 6'd8;
	localparam logic [KIND_BITS-1:0] KIND_ELSE  = 6'd9;
	localparam logic [KIND_BITS-1:0] KIND_MATCH = 6'd10;
	localparam logic [KIND_BITS-1:0] KIND_T0U   = 6'd11;
	localparam logic [KIND_BITS-1:0] KIND_T64I  = 6'd12;
	localparam logic [KIND_BITS-1:0] KIND_T64U  = 6'd13;
	localparam logic [KIND_BITS-1:0] KIND_T32I  = 6'd14;
	localparam logic [KIND_BITS-1:0] KIND_T32U  = 6'd15;
	localparam logic [KIND_BITS-1:0] KIND_T16I  = 6'd16;
	localparam logic [KIND_BITS-1:0] KIND_T16U  = 6'd17;
	localparam logic [KIND_BITS-1:0] KIND_T8I   = 6'd18;
	localparam logic [KIND_BITS-1:0] KIND_T8U   = 6'd19;
	localparam logic [KIND_BITS-1:0] KIND_T64F  = 6'd20;
	localparam logic [KIND_BITS-1:0] KIND_LPAR  = 6'd21;
	localparam logic [KIND_BITS-1:0] KIND_RPAR  = 6'd22;
	localparam logic [KIND_BITS-1:0] KIND_LBRC  = 6'd23;
	localparam logic [KIND_BITS-1:0] KIND_RBRC  = 6'd24;
	localparam logic [KIND_BITS-1:0] KIND_SEMI  = 6'd25;
	localparam logic [KIND_BITS-1:0] KIND_COLON = 6'd26;
	localparam logic [KIND_BITS-1:0] KIND_COMMA = 6'd27;
	localparam logic [KIND_BITS-1:0] KIND_ASSN  = 6'd28;
	localparam logic [KIND_BITS-1:0] KIND_EQ    = 6'd29;
	localparam logic [KIND_BITS-1:0] KIND_LT    = 6'd30;
	localparam logic [KIND_BITS-1:0] KIND_LE    = 6'd31;
	localparam logic [KIND_BITS-1:0] KIND_GT    = 6'd32;
	localparam logic [KIND_BITS-1:0] KIND_GE    = 6'd33;
	localparam logic [KIND_BITS-1:0] KIND_NOT   = 6'd34;
	localparam logic [KIND_BITS-1:0] KIND_NE    = 6'd35;
	localparam logic [KIND_BITS-1:0] KIND_PLUS  = 6'd36;
	localparam logic [KIND_BITS-1:0] KIND_INC   = 6'd37;
	localparam logic [KIND_BITS-1:0] KIND_MINUS = 6'd38;
	localparam logic [KIND_BITS-1:0] KIND_ARROW = 6'd39;
	localparam logic [KIND_BITS-1:0] KIND_DEC   = 6'd40;
	localparam logic [KIND_BITS-1:0] KIND_STAR  = 6'd41;
	localparam logic [KIND_BITS-1:0] KIND_AMP   = 6'd42;
	localparam logic [KIND_BITS-1:0] KIND_ERROR = 6'd43;

	// one token as delivered
	typedef struct packed {
		logic [KIND_BITS-1:0] kind;
		logic [OUT_BITS-1:0]  start;
		logic [OUT_BITS-1:0]  len;
	} token_t;

	// all tokens caused by one byte (one or two)
	typedef struct packed {
		token_t first;
		token_t second;
		logic   two;
	} group_t;

	// scanner to queue write port
	typedef struct packed {
		logic   valid;
		group_t grp;
	} push_t;

	// queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

// File: hdl/stt_in_if.sv
interface stt_in_if;
	import stt_pkg::*;

	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       end_of_text;

	modport source (output valid, output char_code, output end_of_text, input ready);
	modport sink (input valid, input char_code, input end_of_text, output ready);

endinterface

// File: hdl/stt_out_if.sv
interface stt_out_if;
	import stt_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [KIND_BITS-1:0] token_kind;
	logic [OUT_BITS-1:0]  start_offset;
	logic [OUT_BITS-1:0]  token_length;
	logic                 last_of_run;

	modport source (output valid, output token_kind, output start_offset,
		output token_length, output last_of_run, input ready);
	modport sink (input valid, input token_kind, input start_offset,
		input token_length, input last_of_run, output ready);

endinterface

// File: hdl/stt_front.sv
module stt_front
	import stt_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	stt_in_if.sink text,
	input  qstat_t qstat,
	output push_t  push
);

	typedef enum logic [3:0] {
		MODE_IDLE   = 4'b0001,
		MODE_WORD   = 4'b0010,
		MODE_NUMBER = 4'b0100,
		MODE_OPER   = 4'b1000
	} mode_t;

	localparam int XW = (POS_BITS > OUT_BITS) ? POS_BITS : OUT_BITS;

	mode_t               mode_q, mode_n;
	logic [47:0]         word_q, word_n;
	logic [15:0]         digits_q, digits_n;
	logic [7:0]          pend_q, pend_n;
	logic [POS_BITS-1:0] start_q, start_n;
	logic [POS_BITS-1:0] run_q, run_n;
	logic [POS_BITS-1:0] pos_q, pos_n;

	logic       accept;
	logic [7:0] c;
	logic       is_let, is_dig, is_blank, is_pair;
	logic       do_idle;
	logic       va, vb, vc;
	token_t     ta, tb, tc;
	logic [6:0] type_res, pair_res;

	function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	function automatic logic [OUT_BITS-1:0] clip(input logic [POS_BITS-1:0] v);
		logic [XW-1:0] x;
		x = XW'(v);
		if (x > XW'({OUT_BITS{1'b1}}))
			return '1;
		return x[OUT_BITS-1:0];
	endfunction

	// keyword lookup on the last six letters of a word
	function automatic logic [KIND_BITS-1:0] word_kind(input logic [47:0] w,
			input logic [POS_BITS-1:0] n);
		logic [KIND_BITS-1:0] k;
		k = KIND_ID;
		if (n == POS_BITS'(3) && w[23:0] == "def")
			k = KIND_DEF;
		else if (n == POS_BITS'(5) && w[39:0] == "while")
			k = KIND_WHILE;
		else if (n == POS_BITS'(3) && w[23:0] == "for")
			k = KIND_FOR;
		else if (n == POS_BITS'(3) && w[23:0] == "let")
			k = KIND_LET;
		else if (n == POS_BITS'(6) && w == "return")
			k = KIND_RET;
		else if (n == POS_BITS'(2) && w[15:0] == "if")
			k = KIND_IF;
		else if (n == POS_BITS'(4) && w[31:0] == "elif")
			k = KIND_ELIF;
		else if (n == POS_BITS'(4) && w[31:0] == "else")
			k = KIND_ELSE;
		else if (n == POS_BITS'(5) && w[39:0] == "match")
			k = KIND_MATCH;
		return k;
	endfunction

	// one-character operator, error for anything else
	function automatic logic [KIND_BITS-1:0] single_kind(input logic [7:0] ch);
		logic [KIND_BITS-1:0] k;
		unique case (ch)
			"(":     k = KIND_LPAR;
			")":     k = KIND_RPAR;
			"{":     k = KIND_LBRC;
			"}":     k = KIND_RBRC;
			";":     k = KIND_SEMI;
			":":     k = KIND_COLON;
			",":     k = KIND_COMMA;
			"=":     k = KIND_ASSN;
			"<":     k = KIND_LT;
			">":     k = KIND_GT;
			"!":     k = KIND_NOT;
			"+":     k = KIND_PLUS;
			"-":     k = KIND_MINUS;
			"*":     k = KIND_STAR;
			"&":     k = KIND_AMP;
			default: k = KIND_ERROR;
		endcase
		return k;
	endfunction

	// {hit, kind} for two-character operators
	function automatic logic [6:0] pair_kind(input logic [7:0] a, input logic [7:0] b);
		logic [6:0] r;
		r = '0;
		if (a == "=" && b == "=")
			r = {1'b1, KIND_EQ};
		else if (a == "<" && b == "=")
			r = {1'b1, KIND_LE};
		else if (a == ">" && b == "=")
			r = {1'b1, KIND_GE};
		else if (a == "!" && b == "=")
			r = {1'b1, KIND_NE};
		else if (a == "+" && (b == "=" || b == "+"))
			r = {1'b1, KIND_INC};
		else if (a == "-" && b == ">")
			r = {1'b1, KIND_ARROW};
		else if (a == "-" && (b == "-" || b == "="))
			r = {1'b1, KIND_DEC};
		return r;
	endfunction

	// {hit, kind} for a digit run closed by a type letter
	function automatic logic [6:0] type_kind(input logic [15:0] d, input logic [7:0] l,
			input logic [POS_BITS-1:0] n);
		logic [6:0]  r;
		logic [15:0] k2;
		logic [23:0] k3;
		r = '0;
		k2 = {d[7:0], l};
		k3 = {d, l};
		if (n == POS_BITS'(1)) begin
			if (k2 == "0U")
				r = {1'b1, KIND_T0U};
			else if (k2 == "8I")
				r = {1'b1, KIND_T8I};
			else if (k2 == "8U")
				r = {1'b1, KIND_T8U};
		end else if (n == POS_BITS'(2)) begin
			if (k3 == "64I")
				r = {1'b1, KIND_T64I};
			else if (k3 == "64U")
				r = {1'b1, KIND_T64U};
			else if (k3 == "32I")
				r = {1'b1, KIND_T32I};
			else if (k3 == "32U")
				r = {1'b1, KIND_T32U};
			else if (k3 == "16I")
				r = {1'b1, KIND_T16I};
			else if (k3 == "16U")
				r = {1'b1, KIND_T16U};
			else if (k3 == "64F")
				r = {1'b1, KIND_T64F};
		end
		return r;
	endfunction

	assign text.ready = !qstat.full;
	assign accept = text.valid && text.ready;
	assign c = text.char_code;

	// byte classes
	assign is_let = (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	assign is_dig = (c >= "0" && c <= "9");
	assign is_blank = (c == 8'h0A) || (c == 8'h0D) || (c == " ") || (c == 8'h09);
	assign is_pair = (c == "=") || (c == "<") || (c == ">") || (c == "!") ||
		(c == "+") || (c == "-");

	assign type_res = type_kind(digits_q, c, run_q);
	assign pair_res = pair_kind(pend_q, c);

	// next scanner state and the tokens of this byte, in order ta, tb, tc
	always_comb begin
		mode_n = mode_q;
		word_n = word_q;
		digits_n = digits_q;
		pend_n = pend_q;
		start_n = start_q;
		run_n = run_q;
		pos_n = pos_q;
		do_idle = 1'b0;
		va = 1'b0;
		vb = 1'b0;
		vc = 1'b0;
		ta = '0;
		tb = '0;
		tc = '0;

		unique case (mode_q)
			MODE_WORD: begin
				if (is_let) begin
					word_n = {word_q[39:0], c};
					run_n = sat_inc(run_q);
				end else begin
					va = 1'b1;
					ta = '{word_kind(word_q, run_q), clip(start_q), clip(run_q)};
					do_idle = 1'b1;
				end
			end
			MODE_NUMBER: begin
				if (is_dig) begin
					digits_n = {digits_q[7:0], c};
					run_n = sat_inc(run_q);
				end else if (is_let && type_res[6]) begin
					va = 1'b1;
					ta = '{type_res[5:0], clip(start_q), clip(sat_inc(run_q))};
					mode_n = MODE_IDLE;
				end else begin
					va = 1'b1;
					ta = '{KIND_INT, clip(start_q), clip(run_q)};
					do_idle = 1'b1;
				end
			end
			MODE_OPER: begin
				va = 1'b1;
				if (pair_res[6]) begin
					ta = '{pair_res[5:0], clip(start_q), OUT_BITS'(2)};
					mode_n = MODE_IDLE;
				end else begin
					ta = '{single_kind(pend_q), clip(start_q), OUT_BITS'(1)};
					do_idle = 1'b1;
				end
			end
			default: do_idle = 1'b1;
		endcase

		// a byte seen with nothing pending
		if (do_idle) begin
			mode_n = MODE_IDLE;
			if (is_blank) begin
				mode_n = MODE_IDLE;
			end else if (is_let) begin
				mode_n = MODE_WORD;
				word_n = 48'(c);
				start_n = pos_q;
				run_n = POS_BITS'(1);
			end else if (is_dig) begin
				mode_n = MODE_NUMBER;
				digits_n = 16'(c);
				start_n = pos_q;
				run_n = POS_BITS'(1);
			end else if (is_pair) begin
				mode_n = MODE_OPER;
				pend_n = c;
				start_n = pos_q;
				run_n = POS_BITS'(1);
			end else begin
				vb = 1'b1;
				tb = '{single_kind(c), clip(pos_q), OUT_BITS'(1)};
			end
		end

		// end of text flushes whatever is pending
		if (text.end_of_text) begin
			unique case (mode_n)
				MODE_WORD: begin
					vc = 1'b1;
					tc = '{word_kind(word_n, run_n), clip(start_n), clip(run_n)};
				end
				MODE_NUMBER: begin
					vc = 1'b1;
					tc = '{KIND_INT, clip(start_n), clip(run_n)};
				end
				MODE_OPER: begin
					vc = 1'b1;
					tc = '{single_kind(pend_n), clip(start_n), OUT_BITS'(1)};
				end
				default: vc = 1'b0;
			endcase
			mode_n = MODE_IDLE;
			pos_n = '0;
		end else begin
			pos_n = sat_inc(pos_q);
		end
	end

	// pack up to two tokens into one queue entry
	always_comb begin
		push.valid = accept && (va || vb || vc);
		push.grp.first = va ? ta : (vb ? tb : tc);
		push.grp.second = (va && vb) ? tb : tc;
		push.grp.two = (2'(va) + 2'(vb) + 2'(vc)) == 2'd2;
	end

	// scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			word_q <= '0;
			digits_q <= '0;
			pend_q <= '0;
			start_q <= '0;
			run_q <= '0;
			pos_q <= '0;
		end else if (accept) begin
			mode_q <= mode_n;
			word_q <= word_n;
			digits_q <= digits_n;
			pend_q <= pend_n;
			start_q <= start_n;
			run_q <= run_n;
			pos_q <= pos_n;
		end
	end

endmodule

// File: hdl/stt_queue.sv
module stt_queue
	import stt_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  push_t  push,
	input  logic   pop,
	output group_t head,
	output qstat_t qstat
);

	group_t               mem_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_q, rd_q;
	logic [QPTR_BITS:0]   cnt_q;
	logic                 do_push, do_pop;

	assign qstat.full = (cnt_q == (QPTR_BITS+1)'(QUEUE_DEPTH));
	assign qstat.empty = (cnt_q == '0);
	assign do_push = push.valid && !qstat.full;
	assign do_pop = pop && !qstat.empty;
	assign head = mem_q[rd_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= push.grp;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= wr_q + 1'b1;
			if (do_pop)
				rd_q <= rd_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// File: hdl/stt_back.sv
module stt_back
	import stt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  group_t     head,
	input  qstat_t     qstat,
	output logic       pop,
	stt_out_if.source  tokens
);

	group_t cur_q;
	logic   vld_q;
	logic   sel_q;
	logic   take, load;
	token_t tok;

	assign take = vld_q && tokens.ready;
	assign load = !vld_q || (take && (!cur_q.two || sel_q));
	assign pop = load && !qstat.empty;

	// present the selected token of the current entry
	assign tok = sel_q ? cur_q.second : cur_q.first;
	assign tokens.valid = vld_q;
	assign tokens.token_kind = tok.kind;
	assign tokens.start_offset = tok.start;
	assign tokens.token_length = tok.len;
	assign tokens.last_of_run = !cur_q.two || sel_q;

	// entry payload
	always_ff @(posedge clk) begin
		if (load)
			cur_q <= head;
	end

	// output control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			sel_q <= 1'b0;
		end else if (load) begin
			vld_q <= !qstat.empty;
			sel_q <= 1'b0;
		end else if (take) begin
			sel_q <= 1'b1;
		end
	end

endmodule

// File: hdl/source_text_tokenizer.sv
// Streaming tokenizer for source text.
// Input channel "text" carries one byte (char_code) per item plus end_of_text,
// which marks the last byte of a text and flushes any pending token.
// Output channel "tokens" carries one token per item: kind, start offset,
// length, and last_of_run, which is set on the final token a byte caused.
// Both channels move an item when valid and ready are high at a clock edge.
// Throughput: one byte per cycle while the token queue is not full. A byte
// yields zero, one or two tokens; a byte with two tokens presents them on
// the output one after the other. A completed token passes through the token
// queue and then the output register. Tokens that need lookahead (words,
// numbers, operator pairs) complete on the following byte or on end_of_text.
// A four-entry token queue sits between the scanner and the output register;
// the scanner drops ready only while that queue is full, so a stalled
// receiver back-pressures the input once four byte groups wait in the queue.
// Reset (arst_n low) returns the scanner to idle at offset zero and empties
// the queue and the output register.
module source_text_tokenizer
	import stt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	stt_in_if.sink    text,
	stt_out_if.source tokens
);

	push_t  push;
	qstat_t qstat;
	group_t head;
	logic   pop;

	stt_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text),
		.qstat  (qstat),
		.push   (push)
	);

	stt_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.qstat  (qstat)
	);

	stt_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.qstat  (qstat),
		.pop    (pop),
		.tokens (tokens)
	);

endmodule

// File: test/tokenizer_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the tokenizer, predicts the tokens of every
// accepted byte and compares them in order with the tokens delivered.
module tokenizer_checker
	import stt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	stt_in_if    text,
	stt_out_if   tokens,
	output int   fail_count,
	output int   tokens_due
);

	typedef enum logic [1:0] {SCAN_IDLE, SCAN_WORD, SCAN_NUMBER, SCAN_OPER} scan_mode_e;

	typedef struct packed {
		logic [KIND_BITS-1:0] kind;
		logic [OUT_BITS-1:0]  start;
		logic [OUT_BITS-1:0]  len;
		logic                 last;
	} token_rec_t;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// keyword spellings, right aligned, with their lengths and kinds
	localparam logic [47:0] KEY_TEXT [9] = '{"def", "while", "for", "let", "return",
		"if", "elif", "else", "match"};
	localparam int KEY_LEN [9] = '{3, 5, 3, 3, 6, 2, 4, 4, 5};
	localparam logic [KIND_BITS-1:0] KEY_KIND [9] = '{KIND_DEF, KIND_WHILE, KIND_FOR,
		KIND_LET, KIND_RET, KIND_IF, KIND_ELIF, KIND_ELSE, KIND_MATCH};

	// type spellings: digits plus one suffix letter
	localparam logic [23:0] TYPE_TEXT [10] = '{"0U", "64I", "64U", "32I", "32U",
		"16I", "16U", "8I", "8U", "64F"};
	localparam int TYPE_LEN [10] = '{2, 3, 3, 3, 3, 3, 3, 2, 2, 3};
	localparam logic [KIND_BITS-1:0] TYPE_KIND [10] = '{KIND_T0U, KIND_T64I, KIND_T64U,
		KIND_T32I, KIND_T32U, KIND_T16I, KIND_T16U, KIND_T8I, KIND_T8U, KIND_T64F};

	// scanner state
	scan_mode_e          scan_mode;
	logic [47:0]         word_chars;
	logic [15:0]         digit_chars;
	logic [7:0]          held_op;
	logic [POS_BITS-1:0] tok_start;
	logic [POS_BITS-1:0] run_len;
	logic [POS_BITS-1:0] byte_pos;

	token_rec_t step_tokens [2];
	int         step_count;
	token_rec_t expected_tokens [$];

	function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	function automatic logic [OUT_BITS-1:0] clip_out(input logic [POS_BITS-1:0] v);
		longint unsigned w;
		longint unsigned lim;
		w = v;
		lim = (64'd1 << OUT_BITS) - 64'd1;
		return (w > lim) ? '1 : w[OUT_BITS-1:0];
	endfunction

	function automatic bit is_letter(input logic [7:0] c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	function automatic bit is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit is_blank(input logic [7:0] c);
		return c == CH_LF || c == CH_CR || c == CH_SPACE || c == CH_TAB;
	endfunction

	function automatic bit may_pair(input logic [7:0] c);
		return c == "=" || c == "<" || c == ">" || c == "!" || c == "+" || c == "-";
	endfunction

	function automatic logic [KIND_BITS-1:0] single_kind(input logic [7:0] c);
		case (c)
			"(": return KIND_LPAR;
			")": return KIND_RPAR;
			"{": return KIND_LBRC;
			"}": return KIND_RBRC;
			";": return KIND_SEMI;
			":": return KIND_COLON;
			",": return KIND_COMMA;
			"=": return KIND_ASSN;
			"<": return KIND_LT;
			">": return KIND_GT;
			"!": return KIND_NOT;
			"+": return KIND_PLUS;
			"-": return KIND_MINUS;
			"*": return KIND_STAR;
			"&": return KIND_AMP;
			default: return KIND_ERROR;
		endcase
	endfunction

	// two-character operators; ERROR stands for no pair
	function automatic bit find_pair(input logic [7:0] a, input logic [7:0] b,
		output logic [KIND_BITS-1:0] kind);
		kind = KIND_ERROR;
		case (a)
			"=": if (b == "=") kind = KIND_EQ;
			"<": if (b == "=") kind = KIND_LE;
			">": if (b == "=") kind = KIND_GE;
			"!": if (b == "=") kind = KIND_NE;
			"+": if (b == "=" || b == "+") kind = KIND_INC;
			"-": begin
				if (b == ">")
					kind = KIND_ARROW;
				else if (b == "-" || b == "=")
					kind = KIND_DEC;
			end
			default: ;
		endcase
		return kind != KIND_ERROR;
	endfunction

	// digit run plus one letter against the type list
	function automatic bit find_type(input logic [7:0] letter,
		output logic [KIND_BITS-1:0] kind);
		logic [23:0] spell;
		kind = KIND_ERROR;
		if (run_len != 1 && run_len != 2)
			return 1'b0;
		spell = (run_len == 1) ? {8'h00, digit_chars[7:0], letter} : {digit_chars, letter};
		for (int i = 0; i < 10; i++) begin
			if (TYPE_LEN[i] == run_len + 1 && spell == TYPE_TEXT[i]) begin
				kind = TYPE_KIND[i];
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic logic [KIND_BITS-1:0] word_kind();
		for (int i = 0; i < 9; i++) begin
			if (run_len == KEY_LEN[i] &&
				(word_chars & ((48'd1 << (8 * KEY_LEN[i])) - 48'd1)) == KEY_TEXT[i])
				return KEY_KIND[i];
		end
		return KIND_ID;
	endfunction

	task automatic add_token(input logic [KIND_BITS-1:0] kind,
		input logic [POS_BITS-1:0] start, input logic [POS_BITS-1:0] len);
		if (step_count < 2) begin
			step_tokens[step_count] = '{kind, clip_out(start), clip_out(len), 1'b0};
			step_count++;
		end
	endtask

	// byte seen with no token pending
	task automatic start_token(input logic [7:0] c, input logic [POS_BITS-1:0] p);
		scan_mode = SCAN_IDLE;
		if (is_blank(c)) begin
			return;
		end else if (is_letter(c)) begin
			scan_mode = SCAN_WORD;
			word_chars = {40'd0, c};
			tok_start = p;
			run_len = 1;
		end else if (is_digit(c)) begin
			scan_mode = SCAN_NUMBER;
			digit_chars = {8'd0, c};
			tok_start = p;
			run_len = 1;
		end else if (may_pair(c)) begin
			scan_mode = SCAN_OPER;
			held_op = c;
			tok_start = p;
			run_len = 1;
		end else begin
			add_token(single_kind(c), p, 1);
		end
	endtask

	// advance the scanner by one byte and queue the tokens it completes
	task automatic scan_byte(input logic [7:0] c, input logic eot);
		logic [POS_BITS-1:0]  p;
		logic [KIND_BITS-1:0] k;
		p = byte_pos;
		step_count = 0;
		case (scan_mode)
			SCAN_WORD: begin
				if (is_letter(c)) begin
					word_chars = {word_chars[39:0], c};
					run_len = sat_inc(run_len);
				end else begin
					add_token(word_kind(), tok_start, run_len);
					start_token(c, p);
				end
			end
			SCAN_NUMBER: begin
				if (is_digit(c)) begin
					digit_chars = {digit_chars[7:0], c};
					run_len = sat_inc(run_len);
				end else if (is_letter(c) && find_type(c, k)) begin
					add_token(k, tok_start, sat_inc(run_len));
					scan_mode = SCAN_IDLE;
				end else begin
					add_token(KIND_INT, tok_start, run_len);
					start_token(c, p);
				end
			end
			SCAN_OPER: begin
				if (find_pair(held_op, c, k)) begin
					add_token(k, tok_start, 2);
					scan_mode = SCAN_IDLE;
				end else begin
					add_token(single_kind(held_op), tok_start, 1);
					start_token(c, p);
				end
			end
			default: start_token(c, p);
		endcase

		// end of text flushes whatever is pending and rewinds the offset
		if (eot) begin
			case (scan_mode)
				SCAN_WORD:   add_token(word_kind(), tok_start, run_len);
				SCAN_NUMBER: add_token(KIND_INT, tok_start, run_len);
				SCAN_OPER:   add_token(single_kind(held_op), tok_start, 1);
				default: ;
			endcase
			scan_mode = SCAN_IDLE;
			byte_pos = '0;
		end else begin
			byte_pos = sat_inc(p);
		end

		if (step_count > 0)
			step_tokens[step_count - 1].last = 1'b1;
		for (int i = 0; i < step_count; i++)
			expected_tokens.push_back(step_tokens[i]);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	// compare delivered tokens, then predict from the accepted byte
	always @(posedge clk or negedge arst_n) begin
		token_rec_t want;
		if (!arst_n) begin
			scan_mode = SCAN_IDLE;
			word_chars = '0;
			digit_chars = '0;
			held_op = '0;
			tok_start = '0;
			run_len = '0;
			byte_pos = '0;
			expected_tokens.delete();
			fail_count = 0;
			tokens_due = 0;
		end else begin
			if (tokens.valid && tokens.ready) begin
				if (expected_tokens.size() == 0) begin
					$error("token with none expected: kind %0d, start %0d, length %0d",
						tokens.token_kind, tokens.start_offset, tokens.token_length);
					fail_count++;
				end else begin
					want = expected_tokens.pop_front();
					check_field("token_kind", want.kind, tokens.token_kind);
					check_field("start_offset", want.start, tokens.start_offset);
					check_field("token_length", want.len, tokens.token_length);
					check_field("last_of_run", want.last, tokens.last_of_run);
				end
			end
			if (text.valid && text.ready)
				scan_byte(text.char_code, text.end_of_text);
			tokens_due = expected_tokens.size();
		end
	end

endmodule

// File: test/tb_source_text_tokenizer.sv
`timescale 1ns / 1ps

module tb_source_text_tokenizer;
	import stt_pkg::*;

	localparam int PHASE_BYTES = 225;
	localparam int LONG_WORD = 40;
	localparam int QUIET_LIMIT = 2000;
	localparam int TAIL_CYCLES = 20;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       src_valid = 1'b0;
	logic [7:0] src_char = 8'h00;
	logic       src_eot = 1'b0;
	logic       sink_ready = 1'b0;
	int         idle_pct = 0;
	int         stall_pct = 0;
	int         text_bytes;
	int         fail_count;
	int         tokens_due;

	string keyword_spell [9] = '{"def", "while", "for", "let", "return", "if", "elif",
		"else", "match"};
	string type_spell [10] = '{"0U", "64I", "64U", "32I", "32U", "16I", "16U", "8I",
		"8U", "64F"};
	string operator_spell [24] = '{"(", ")", "{", "}", ";", ":", ",", "=", "==", "<",
		"<=", ">", ">=", "!", "!=", "+", "++", "+=", "-", "->", "--", "-=", "*", "&"};
	string pair_starts = "=<>!+-";

	stt_in_if  text_ch ();
	stt_out_if token_ch ();

	assign text_ch.valid = src_valid;
	assign text_ch.char_code = src_char;
	assign text_ch.end_of_text = src_eot;
	assign token_ch.ready = sink_ready;

	source_text_tokenizer i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_ch),
		.tokens (token_ch)
	);

	tokenizer_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.text       (text_ch),
		.tokens     (token_ch),
		.fail_count (fail_count),
		.tokens_due (tokens_due)
	);

	initial forever #5 clk = ~clk;

	// receiver back-pressure
	always @(posedge clk) begin
		sink_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	function automatic logic [7:0] rand_letter();
		logic [7:0] base;
		base = $urandom_range(0, 1) ? "A" : "a";
		return base + 8'($urandom_range(0, 25));
	endfunction

	function automatic logic [7:0] rand_blank();
		case ($urandom_range(0, 3))
			0: return 8'h20;
			1: return 8'h09;
			2: return 8'h0A;
			default: return 8'h0D;
		endcase
	endfunction

	// offer one byte, idling first at random, and hold it until accepted
	task automatic send_byte(input logic [7:0] c, input logic eot);
		while ($urandom_range(0, 99) < idle_pct) begin
			src_valid <= 1'b0;
			@(posedge clk);
		end
		src_valid <= 1'b1;
		src_char <= c;
		src_eot <= eot;
		@(posedge clk);
		while (!text_ch.ready)
			@(posedge clk);
	endtask

	// end of text goes on the last byte only
	task automatic send_bytes(input logic [7:0] b [$], input logic eot);
		for (int i = 0; i < b.size(); i++)
			send_byte(b[i], eot && (i == b.size() - 1));
	endtask

	task automatic push_text(ref logic [7:0] b [$], input string s);
		for (int i = 0; i < s.len(); i++)
			b.push_back(s[i]);
	endtask

	task automatic send_text(input string s, input logic eot);
		logic [7:0] b [$];
		push_text(b, s);
		send_bytes(b, eot);
	endtask

	// one lexeme, mostly well formed, with noise and broken pieces mixed in
	task automatic send_random_lexeme();
		logic [7:0] b [$];
		int         pick;
		int         n;
		pick = $urandom_range(0, 99);
		if (pick < 16) begin
			push_text(b, keyword_spell[$urandom_range(0, 8)]);
		end else if (pick < 34) begin
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
			repeat (n) b.push_back(rand_letter());
		end else if (pick < 48) begin
			n = $urandom_range(1, 4);
			repeat (n) b.push_back(8'("0" + $urandom_range(0, 9)));
		end else if (pick < 60) begin
			push_text(b, type_spell[$urandom_range(0, 9)]);
			if ($urandom_range(0, 3) == 0)
				b.push_back(rand_letter());
		end else if (pick < 84) begin
			push_text(b, operator_spell[$urandom_range(0, 23)]);
		end else if (pick < 92) begin
			b.push_back(8'($urandom_range(0, 255)));
		end else if ($urandom_range(0, 1)) begin
			b.push_back(8'("0" + $urandom_range(0, 9)));
			b.push_back(rand_letter());
		end else begin
			b.push_back(pair_starts[$urandom_range(0, 5)]);
			b.push_back(8'($urandom_range(0, 255)));
		end
		send_bytes(b, $urandom_range(0, 24) == 0);
		text_bytes += b.size();
		if ($urandom_range(0, 99) < 60) begin
			send_byte(rand_blank(), $urandom_range(0, 49) == 0);
			text_bytes++;
		end
	endtask

	// no acceptance on either side for too long ends the run
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((src_valid && text_ch.ready) || (token_ch.valid && sink_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("source_text_tokenizer: mismatch");
		$finish;
	end

	initial begin : stimulus
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: word cut by a high byte, number with a non-type letter,
		// type followed by a letter, arrow, lone operator, NUL, a keyword,
		// long word, pending operator flushed at end of text
		send_text("ab", 1'b0);
		send_byte(8'hFF, 1'b0);
		send_text("7q 16Ux\t-><", 1'b0);
		send_byte(8'h00, 1'b0);
		send_text("elif matchbox+", 1'b1);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = 64;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 64;
				end
				default: begin
					idle_pct = 18;
					stall_pct = 18;
				end
			endcase
			text_bytes = 0;
			while (text_bytes < PHASE_BYTES)
				send_random_lexeme();
		end

		// a long word, then a few tokens behind it in the same text
		idle_pct = 0;
		stall_pct = 0;
		send_byte(8'h20, 1'b1);
		repeat (LONG_WORD) send_byte(rand_letter(), 1'b0);
		send_text(";8U-", 1'b1);
		src_valid <= 1'b0;

		// drain, then give stray tokens a chance to show up
		do
			@(negedge clk);
		while (tokens_due != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		@(negedge clk);
		if (fail_count == 0)
			$display("source_text_tokenizer: match");
		else
			$display("source_text_tokenizer: mismatch");
		$finish;
	end

endmodule
